// ===== sv/nsl_pkg.sv =====
`timescale 1ns / 1ps

package nsl_pkg;

  // command codes
  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_SECTION = 2'd1;
  localparam logic [1:0] CMD_SYMBOL  = 2'd2;
  localparam logic [1:0] CMD_QUERY   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_HIT  = 2'd3;

  // nearest-symbol distance must stay below this
  localparam logic [30:0] DIST_LIMIT = 31'h7fffffff;

  // memory word layouts
  localparam int SEC_WORD_W = 62;  // {base[31:0], words[29:0]}
  localparam int SYM_WORD_W = 36;  // {owner[3:0], addr[31:0]}

  // query engine answer toward the top level
  typedef struct packed {
    logic        done;
    logic        hit;
    logic [7:0]  ordinal;
    logic [31:0] value;
  } qry_res_t;

endpackage

// ===== sv/nsl_ram.sv =====
`timescale 1ns / 1ps

module nsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/nsl_query.sv =====
`timescale 1ns / 1ps

module nsl_query
  import nsl_pkg::*;
#(
  parameter int MAX_SECTIONS = 16,
  parameter int MAX_SYMBOLS  = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [31:0] query_addr,
  input  logic [$clog2(MAX_SECTIONS+1)-1:0] sec_count,
  input  logic [$clog2(MAX_SYMBOLS+1)-1:0]  sym_count,
  output logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] sec_raddr,
  input  logic [SEC_WORD_W-1:0] sec_rdata,
  output logic [((MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1)-1:0] sym_raddr,
  input  logic [SYM_WORD_W-1:0] sym_rdata,
  input  logic ack,
  output qry_res_t res
);

  localparam int SCW = $clog2(MAX_SECTIONS + 1);
  localparam int YCW = $clog2(MAX_SYMBOLS + 1);
  localparam int SW  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int YW  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SEC  = 2'd1;
  localparam logic [1:0] S_SYM  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]     state_r, state_nxt;
  logic [31:0]    addr_r, addr_nxt;
  logic [SCW-1:0] sec_rd_r, sec_rd_nxt;
  logic [YCW-1:0] sym_rd_r, sym_rd_nxt;
  logic           pend_r, pend_nxt;
  logic [SW-1:0]  pend_sec_r, pend_sec_nxt;
  logic [YW-1:0]  pend_sym_r, pend_sym_nxt;
  logic [SW-1:0]  sel_r, sel_nxt;
  logic [30:0]    best_dist_r, best_dist_nxt;
  logic [YW-1:0]  best_idx_r, best_idx_nxt;
  logic [31:0]    best_addr_r, best_addr_nxt;
  logic           have_r, have_nxt;

  // section and symbol words from memory
  logic [31:0]    sec_lo, sec_hi, sym_a, gap;
  logic [3:0]     sym_own;
  logic           in_range, owner_eq;
  logic [SW+3:0]  own_ext, sel_ext;
  logic [YW+7:0]  ord_ext;

  assign sec_lo   = sec_rdata[61:30];
  assign sec_hi   = sec_lo + {sec_rdata[29:0], 2'b00};
  assign in_range = (addr_r >= sec_lo) && (addr_r <= sec_hi);

  assign sym_a    = sym_rdata[31:0];
  assign sym_own  = sym_rdata[35:32];
  assign own_ext  = {{SW{1'b0}}, sym_own};
  assign sel_ext  = {4'b0000, sel_r};
  assign owner_eq = (own_ext == sel_ext);
  assign gap      = addr_r - sym_a;

  assign sec_raddr = sec_rd_r[SW-1:0];
  assign sym_raddr = sym_rd_r[YW-1:0];

  // answer, ordinal taken modulo 256
  assign ord_ext     = {8'h00, best_idx_r};
  assign res.done    = (state_r == S_DONE);
  assign res.hit     = have_r;
  assign res.ordinal = have_r ? ord_ext[7:0] : 8'h00;
  assign res.value   = have_r ? best_addr_r : 32'h0;

  // scan sequencer: one read issued per cycle, checked the cycle after
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    sec_rd_nxt    = sec_rd_r;
    sym_rd_nxt    = sym_rd_r;
    pend_nxt      = pend_r;
    pend_sec_nxt  = pend_sec_r;
    pend_sym_nxt  = pend_sym_r;
    sel_nxt       = sel_r;
    best_dist_nxt = best_dist_r;
    best_idx_nxt  = best_idx_r;
    best_addr_nxt = best_addr_r;
    have_nxt      = have_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt     = S_SEC;
          addr_nxt      = query_addr;
          sec_rd_nxt    = '0;
          pend_nxt      = 1'b0;
          have_nxt      = 1'b0;
          best_dist_nxt = DIST_LIMIT;
          best_idx_nxt  = '0;
          best_addr_nxt = '0;
        end
      end
      S_SEC: begin
        if (pend_r && in_range) begin
          // first section holding the address wins
          state_nxt  = S_SYM;
          sel_nxt    = pend_sec_r;
          sym_rd_nxt = '0;
          pend_nxt   = 1'b0;
        end else if (sec_rd_r < sec_count) begin
          pend_nxt     = 1'b1;
          pend_sec_nxt = sec_rd_r[SW-1:0];
          sec_rd_nxt   = sec_rd_r + 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SYM: begin
        if (pend_r && owner_eq && (sym_a == addr_r)) begin
          // exact match ends the walk
          state_nxt     = S_DONE;
          have_nxt      = 1'b1;
          best_idx_nxt  = pend_sym_r;
          best_addr_nxt = sym_a;
          pend_nxt      = 1'b0;
        end else begin
          if (pend_r && owner_eq && (sym_a < addr_r) && (gap < {1'b0, best_dist_r})) begin
            have_nxt      = 1'b1;
            best_dist_nxt = gap[30:0];
            best_idx_nxt  = pend_sym_r;
            best_addr_nxt = sym_a;
          end
          if (sym_rd_r < sym_count) begin
            pend_nxt     = 1'b1;
            pend_sym_nxt = sym_rd_r[YW-1:0];
            sym_rd_nxt   = sym_rd_r + 1'b1;
          end else if (pend_r) begin
            pend_nxt = 1'b0;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      have_r  <= have_nxt;
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    sec_rd_r    <= sec_rd_nxt;
    sym_rd_r    <= sym_rd_nxt;
    pend_sec_r  <= pend_sec_nxt;
    pend_sym_r  <= pend_sym_nxt;
    sel_r       <= sel_nxt;
    best_dist_r <= best_dist_nxt;
    best_idx_r  <= best_idx_nxt;
    best_addr_r <= best_addr_nxt;
  end

endmodule

// ===== sv/nearest_symbol_lookup_unit.sv =====
`timescale 1ns / 1ps
// Nearest-symbol lookup unit.
// Input channel (in_valid / in_stall) carries one request: clear, append
// section, append symbol or query address. Every request gives exactly one
// result on the output channel (out_valid / out_stall): status, ordinal and
// symbol address.
// Clear and append requests complete with a registered result: it is valid the
// cycle after the request is taken. A query walks the section memory one
// entry per cycle until the first section holding the address, then the
// symbol memory one entry per cycle. The one-read-per-cycle memory ports
// set that pace. One request is worked on at a time.
// The result sits in an output register; a stalled result holds its value,
// and while it is stalled no new request is taken.
// Reset empties both tables (counts go to zero) and drops any result; the
// memory contents are left as they are and are never read before written.
module nearest_symbol_lookup_unit
  import nsl_pkg::*;
#(
  parameter int MAX_SECTIONS = 16,
  parameter int MAX_SYMBOLS  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_section_start,
  input  logic [29:0] in_section_words,
  input  logic [3:0]  in_symbol_section,
  input  logic [31:0] in_symbol_address,
  input  logic [31:0] in_query_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_symbol_ordinal,
  output logic [31:0] out_symbol_value
);

  localparam int SCW = $clog2(MAX_SECTIONS + 1);
  localparam int YCW = $clog2(MAX_SYMBOLS + 1);
  localparam int SW  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int YW  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  logic [SCW-1:0] sec_count_r, sec_count_nxt;
  logic [YCW-1:0] sym_count_r, sym_count_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     out_status_r, out_status_nxt;
  logic [7:0]     out_ord_r, out_ord_nxt;
  logic [31:0]    out_val_r, out_val_nxt;
  logic           q_run_r, q_run_nxt;

  logic           take, out_free, q_busy, q_start, q_state_busy;
  logic           sec_we, sym_we;
  logic [SW-1:0]  sec_raddr;
  logic [YW-1:0]  sym_raddr;
  logic [SEC_WORD_W-1:0] sec_rdata;
  logic [SYM_WORD_W-1:0] sym_rdata;
  qry_res_t       q_res;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign q_busy   = q_res.done || (q_state_busy);
  assign in_stall = q_busy || !out_free;
  assign take     = in_valid && !in_stall;
  assign q_start  = take && (in_command == CMD_QUERY);

  assign sec_we = take && (in_command == CMD_SECTION) && (sec_count_r < SCW'(MAX_SECTIONS));
  assign sym_we = take && (in_command == CMD_SYMBOL) && (sym_count_r < YCW'(MAX_SYMBOLS));

  // section and symbol tables
  nsl_ram #(
    .WIDTH (SEC_WORD_W),
    .DEPTH (MAX_SECTIONS)
  ) u_sec_ram (
    .clk   (clk),
    .we    (sec_we),
    .waddr (sec_count_r[SW-1:0]),
    .wdata ({in_section_start, in_section_words}),
    .raddr (sec_raddr),
    .rdata (sec_rdata)
  );

  nsl_ram #(
    .WIDTH (SYM_WORD_W),
    .DEPTH (MAX_SYMBOLS)
  ) u_sym_ram (
    .clk   (clk),
    .we    (sym_we),
    .waddr (sym_count_r[YW-1:0]),
    .wdata ({in_symbol_section, in_symbol_address}),
    .raddr (sym_raddr),
    .rdata (sym_rdata)
  );

  // query walk
  nsl_query #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .MAX_SYMBOLS  (MAX_SYMBOLS)
  ) u_query (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (q_start),
    .query_addr (in_query_address),
    .sec_count  (sec_count_r),
    .sym_count  (sym_count_r),
    .sec_raddr  (sec_raddr),
    .sec_rdata  (sec_rdata),
    .sym_raddr  (sym_raddr),
    .sym_rdata  (sym_rdata),
    .ack        (out_free),
    .res        (q_res)
  );

  // query in flight: started and not yet answered
  assign q_state_busy = q_run_r;

  always_comb begin
    q_run_nxt = q_run_r;
    if (q_start) begin
      q_run_nxt = 1'b1;
    end else if (q_res.done && out_free) begin
      q_run_nxt = 1'b0;
    end
  end

  // table counts and result register
  always_comb begin
    sec_count_nxt  = sec_count_r;
    sym_count_nxt  = sym_count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_ord_nxt    = out_ord_r;
    out_val_nxt    = out_val_r;
    if (take && (in_command != CMD_QUERY)) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_ord_nxt    = 8'h00;
      out_val_nxt    = 32'h0;
      case (in_command)
        CMD_CLEAR: begin
          sec_count_nxt = '0;
          sym_count_nxt = '0;
        end
        CMD_SECTION: begin
          if (sec_we) begin
            sec_count_nxt = sec_count_r + 1'b1;
          end else begin
            out_status_nxt = ST_FULL;
          end
        end
        CMD_SYMBOL: begin
          if (sym_we) begin
            sym_count_nxt = sym_count_r + 1'b1;
          end else begin
            out_status_nxt = ST_FULL;
          end
        end
        default: out_status_nxt = ST_OK;
      endcase
    end else if (q_res.done && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = q_res.hit ? ST_HIT : ST_MISS;
      out_ord_nxt    = q_res.ordinal;
      out_val_nxt    = q_res.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_count_r <= '0;
      sym_count_r <= '0;
      out_valid_r <= 1'b0;
      q_run_r     <= 1'b0;
    end else begin
      sec_count_r <= sec_count_nxt;
      sym_count_r <= sym_count_nxt;
      out_valid_r <= out_valid_nxt;
      q_run_r     <= q_run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_ord_r    <= out_ord_nxt;
    out_val_r    <= out_val_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_symbol_ordinal = out_ord_r;
  assign out_symbol_value   = out_val_r;

endmodule

// ===== sim/nsl_answer_checker.sv =====
`timescale 1ns / 1ps

module nsl_answer_checker
  import nsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_section_start,
  input  logic [29:0] in_section_words,
  input  logic [3:0]  in_symbol_section,
  input  logic [31:0] in_symbol_address,
  input  logic [31:0] in_query_address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_symbol_ordinal,
  input  logic [31:0] out_symbol_value,
  output int          fail_count,
  output int          waiting_count,
  output int          found_count
);

  localparam int SECTION_SLOTS = 16;
  localparam int SYMBOL_SLOTS  = 256;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  ordinal;
    logic [31:0] value;
  } symbol_answer_t;

  // shadow copy of the section and symbol tables
  logic [31:0] sec_base  [SECTION_SLOTS];
  logic [29:0] sec_words [SECTION_SLOTS];
  logic [31:0] sym_addr  [SYMBOL_SLOTS];
  logic [3:0]  sym_owner [SYMBOL_SLOTS];
  int sec_count;
  int sym_count;

  symbol_answer_t answers_due[$];
  int errs;
  int found;

  // first section holding the address decides; exact hit, else nearest below
  function automatic symbol_answer_t resolve_address(input logic [31:0] addr);
    symbol_answer_t ans;
    logic [31:0] range_end;
    logic [31:0] best_dist;
    int best;
    bit have;
    bit exact;
    bit claimed;
    ans = '0;
    ans.status = ST_MISS;
    claimed = 1'b0;
    for (int s = 0; s < sec_count && !claimed; s++) begin
      range_end = sec_base[s] + {sec_words[s], 2'b00};
      if (addr >= sec_base[s] && addr <= range_end) begin
        claimed = 1'b1;
        have = 1'b0;
        exact = 1'b0;
        best = 0;
        best_dist = 32'(DIST_LIMIT);
        for (int k = 0; k < sym_count && !exact; k++) begin
          if (sym_owner[k] == 4'(s)) begin
            if (sym_addr[k] == addr) begin
              best = k;
              have = 1'b1;
              exact = 1'b1;
            end else if (sym_addr[k] < addr && (addr - sym_addr[k]) < best_dist) begin
              best_dist = addr - sym_addr[k];
              best = k;
              have = 1'b1;
            end
          end
        end
        if (have) begin
          ans.status = ST_HIT;
          ans.ordinal = 8'(best);
          ans.value = sym_addr[best];
        end
      end
    end
    return ans;
  endfunction

  // update the shadow tables and work out the answer of one request
  function automatic symbol_answer_t apply_request(
    input logic [1:0]  cmd,
    input logic [31:0] start,
    input logic [29:0] words,
    input logic [3:0]  owner,
    input logic [31:0] saddr,
    input logic [31:0] qaddr
  );
    symbol_answer_t ans;
    ans = '0;
    ans.status = ST_OK;
    case (cmd)
      CMD_CLEAR: begin
        sec_count = 0;
        sym_count = 0;
      end
      CMD_SECTION: begin
        if (sec_count >= SECTION_SLOTS) begin
          ans.status = ST_FULL;
        end else begin
          sec_base[sec_count] = start;
          sec_words[sec_count] = words;
          sec_count++;
        end
      end
      CMD_SYMBOL: begin
        if (sym_count >= SYMBOL_SLOTS) begin
          ans.status = ST_FULL;
        end else begin
          sym_owner[sym_count] = owner;
          sym_addr[sym_count] = saddr;
          sym_count++;
        end
      end
      default: begin
        ans = resolve_address(qaddr);
      end
    endcase
    return ans;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    errs++;
    if (errs <= 10)
      $display("mismatch in %s at %0t ns: expected %0h, got %0h", what, $time, want, got);
  endtask

  always @(posedge clk) begin
    symbol_answer_t want;
    if (!rst_n) begin
      sec_count = 0;
      sym_count = 0;
      answers_due.delete();
      errs = 0;
      found = 0;
    end else begin
      // taken result against the oldest answer due
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          flag_mismatch("result with no request", 32'd0, 32'(out_status));
        end else begin
          want = answers_due.pop_front();
          if (out_status !== want.status)
            flag_mismatch("status", 32'(want.status), 32'(out_status));
          if (out_symbol_ordinal !== want.ordinal)
            flag_mismatch("symbol_ordinal", 32'(want.ordinal), 32'(out_symbol_ordinal));
          if (out_symbol_value !== want.value)
            flag_mismatch("symbol_value", want.value, out_symbol_value);
          if (want.status == ST_HIT)
            found++;
        end
      end
      // predict the answer to a taken request
      if (in_valid && !in_stall)
        answers_due.push_back(apply_request(in_command, in_section_start, in_section_words,
                                            in_symbol_section, in_symbol_address,
                                            in_query_address));
    end
    fail_count <= errs;
    waiting_count <= answers_due.size();
    found_count <= found;
  end

endmodule

// ===== sim/nearest_symbol_lookup_unit_tb.sv =====
`timescale 1ns / 1ps

module nearest_symbol_lookup_unit_tb;
  import nsl_pkg::*;

  localparam int SECTION_SLOTS = 16;
  localparam int SYMBOL_SLOTS  = 256;
  localparam int PHASE_ITEMS   = 400;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = CMD_CLEAR;
  logic [31:0] in_section_start = '0;
  logic [29:0] in_section_words = '0;
  logic [3:0]  in_symbol_section = '0;
  logic [31:0] in_symbol_address = '0;
  logic [31:0] in_query_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_symbol_ordinal;
  logic [31:0] out_symbol_value;

  int fail_count;
  int waiting_count;
  int found_count;

  int send_pct = 0;
  int recv_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int items_sent = 0;
  int queries_sent = 0;

  // layout as the stimulus knows it, used to aim queries
  logic [31:0] lay_base  [SECTION_SLOTS];
  logic [29:0] lay_words [SECTION_SLOTS];
  int lay_n = 0;
  logic [31:0] sym_seen[$];

  always #1 clk = ~clk;

  nearest_symbol_lookup_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_section_start   (in_section_start),
    .in_section_words   (in_section_words),
    .in_symbol_section  (in_symbol_section),
    .in_symbol_address  (in_symbol_address),
    .in_query_address   (in_query_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_symbol_ordinal (out_symbol_ordinal),
    .out_symbol_value   (out_symbol_value)
  );

  nsl_answer_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_section_start   (in_section_start),
    .in_section_words   (in_section_words),
    .in_symbol_section  (in_symbol_section),
    .in_symbol_address  (in_symbol_address),
    .in_query_address   (in_query_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_symbol_ordinal (out_symbol_ordinal),
    .out_symbol_value   (out_symbol_value),
    .fail_count         (fail_count),
    .waiting_count      (waiting_count),
    .found_count        (found_count)
  );

  // one request on the input channel, with random idle cycles ahead of it
  task automatic send_req(input logic [1:0] cmd, input logic [31:0] start,
                          input logic [29:0] words, input logic [3:0] owner,
                          input logic [31:0] saddr, input logic [31:0] qaddr);
    while ($urandom_range(99, 0) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_section_start <= start;
    in_section_words <= words;
    in_symbol_section <= owner;
    in_symbol_address <= saddr;
    in_query_address <= qaddr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (cmd == CMD_QUERY)
      queries_sent++;
  endtask

  // unused fields carry random junk
  task automatic clear_tables();
    send_req(CMD_CLEAR, $urandom, 30'($urandom), 4'($urandom), $urandom, $urandom);
    lay_n = 0;
    sym_seen.delete();
  endtask

  task automatic add_section(input logic [31:0] base, input logic [29:0] words);
    send_req(CMD_SECTION, base, words, 4'($urandom), $urandom, $urandom);
    if (lay_n < SECTION_SLOTS) begin
      lay_base[lay_n] = base;
      lay_words[lay_n] = words;
      lay_n++;
    end
  endtask

  task automatic add_symbol(input logic [3:0] owner, input logic [31:0] addr);
    send_req(CMD_SYMBOL, $urandom, 30'($urandom), owner, addr, $urandom);
    if (sym_seen.size() < SYMBOL_SLOTS)
      sym_seen.push_back(addr);
  endtask

  task automatic ask(input logic [31:0] addr);
    send_req(CMD_QUERY, $urandom, 30'($urandom), 4'($urandom), $urandom, addr);
  endtask

  function automatic logic [31:0] spot_in_section(input int s);
    logic [31:0] off;
    off = $urandom_range(32'(lay_words[s]), 0);
    return lay_base[s] + (off << 2);
  endfunction

  // queries aimed at known sections and symbols, some anywhere
  task automatic fire_queries(input int count);
    int s;
    repeat (count) begin
      if (lay_n == 0) begin
        ask($urandom);
      end else begin
        s = $urandom_range(lay_n - 1, 0);
        case ($urandom_range(5, 0))
          0: ask($urandom);
          1: begin
            if (sym_seen.size() > 0)
              ask(sym_seen[$urandom_range(sym_seen.size() - 1, 0)]);
            else
              ask(spot_in_section(s));
          end
          2: ask(lay_base[s] + {lay_words[s], 2'b00});
          default: ask(spot_in_section(s));
        endcase
      end
    end
  endtask

  task automatic place_symbols(input int s, input int count);
    repeat (count) begin
      case ($urandom_range(7, 0))
        0: add_symbol(4'(s), lay_base[s] - $urandom_range(64, 1));
        1: add_symbol(4'($urandom), $urandom);
        default: add_symbol(4'(s), spot_in_section(s));
      endcase
    end
  endtask

  task automatic random_section();
    if ($urandom_range(9, 0) == 0)
      add_section($urandom, 30'($urandom));
    else
      add_section($urandom, 30'($urandom_range(64, 0)));
  endtask

  // fresh layout, growth of the current one, or loose requests
  task automatic run_scene();
    int pick;
    int first;
    pick = $urandom_range(99, 0);
    if (pick < 65) begin
      clear_tables();
      repeat ($urandom_range(6, 1)) random_section();
      for (int s = 0; s < lay_n; s++)
        place_symbols(s, $urandom_range(5, 0));
      fire_queries($urandom_range(8, 3));
    end else if (pick < 80) begin
      repeat ($urandom_range(10, 3)) begin
        case (2'($urandom))
          CMD_CLEAR: clear_tables();
          CMD_SECTION: add_section($urandom, 30'($urandom));
          CMD_SYMBOL: add_symbol(4'($urandom), $urandom);
          default: ask($urandom);
        endcase
      end
    end else begin
      first = lay_n;
      repeat ($urandom_range(3, 1)) random_section();
      for (int s = first; s < lay_n; s++)
        place_symbols(s, $urandom_range(6, 1));
      fire_queries($urandom_range(6, 2));
    end
  endtask

  // both tables to capacity and one append past it, symbols out of order
  task automatic fill_tables();
    clear_tables();
    for (int s = 0; s <= SECTION_SLOTS; s++)
      add_section(32'(s) << 24, 30'($urandom_range(4096, 1)));
    repeat (SYMBOL_SLOTS + 1) begin
      int s;
      s = $urandom_range(SECTION_SLOTS - 1, 0);
      add_symbol(4'(s), spot_in_section(s));
    end
    fire_queries(12);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting_count != 0) @(posedge clk);
  endtask

  // receiver: random stall, or one long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99, 0) < recv_pct);
      end
    end
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", waiting_count);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int phase_end;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_pct = 27;
    recv_pct = 55;

    // directed: empty tables, range edges, wrap, distance limit, ownership
    ask(32'h0000_0000);
    clear_tables();
    add_section(32'h0000_1000, 30'd16);
    add_section(32'hFFFF_FFF0, 30'd8);
    add_section(32'hFFFF_FFFF, 30'd0);
    add_section(32'h0000_0000, 30'h3FFF_FFFF);
    add_symbol(4'd0, 32'h0000_1000);
    add_symbol(4'd0, 32'h0000_1010);
    add_symbol(4'd0, 32'h0000_1010);
    add_symbol(4'd3, 32'h0000_0000);
    add_symbol(4'd9, 32'h0000_2000);
    add_symbol(4'd0, 32'h0000_1008);
    add_symbol(4'd3, 32'h9000_0000);
    ask(32'h0000_1010);
    ask(32'h0000_100C);
    ask(32'h0000_1040);
    ask(32'h0000_0FFF);
    ask(32'hFFFF_FFF8);
    ask(32'hFFFF_FFFF);
    ask(32'h8000_0000);
    ask(32'h7FFF_FFFF);
    ask(32'h7FFF_FFFE);
    ask(32'h0000_2000);
    drain();

    // random phases: sender-light, receiver-light, then no idling
    for (int ph = 0; ph < 3; ph++) begin
      send_pct = (ph == 0) ? 27 : (ph == 1) ? 55 : 0;
      recv_pct = (ph == 0) ? 55 : (ph == 1) ? 27 : 0;
      phase_end = items_sent + PHASE_ITEMS;
      if (ph == 0)
        fill_tables();
      if (ph == 2)
        hold_asked++;
      while (items_sent < phase_end) run_scene();
      drain();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (waiting_count != 0)
      $display("%0d expected results never arrived", waiting_count);
    $display("ran %0d requests, %0d queries, %0d answered with a symbol", items_sent,
             queries_sent, found_count);
    $display("tables filled past capacity, output held off %0d cycles under load",
             HOLD_CYCLES);
    if (fail_count == 0 && waiting_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/nsl_pkg.sv
sv/nsl_ram.sv
sv/nsl_query.sv
sv/nearest_symbol_lookup_unit.sv
sim/nsl_answer_checker.sv
sim/nearest_symbol_lookup_unit_tb.sv
